[rtl/hsa_pkg.sv]
// shared constants for the charge hopping site agent
`default_nettype none

package hsa_pkg;

    // default sizes
    localparam int NEIGHBORS_DEF = 6;
    localparam int RAND_BITS_DEF = 16;

    // weight format, unsigned Q12.12
    localparam int WEIGHT_BITS = 24;

    // item function codes
    localparam logic [1:0] FUNC_TRANSPORT = 2'd0;
    localparam logic [1:0] FUNC_OFFER     = 2'd1;
    localparam logic [1:0] FUNC_COMMIT    = 2'd2;

    // hop barrier after reset, 0.4 in Q0.16
    localparam logic [15:0] BARRIER_RESET = 16'd26214;

    // log2(e) in Q1.16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // cubic for 2^f on [0,1)
    localparam logic [16:0] POLY_C1 = 17'd45590;
    localparam logic [16:0] POLY_C2 = 17'd14809;
    localparam logic [16:0] POLY_C3 = 17'd5137;

    // exponent offset: 16 << 24 minus 2048 * log2(e), so the biased argument stays positive
    localparam logic [28:0] EXP_OFFSET = 29'd74801152;

    // right shift of {p, 7'b0} is this minus the integer part of the biased exponent
    localparam logic [4:0] SHIFT_BASE = 5'd27;

endpackage

`default_nettype wire

[rtl/hsa_mul.sv]
// shared unsigned multiplier with registered product
`default_nettype none

module hsa_mul #(
    parameter int A_BITS = 27,
    parameter int B_BITS = 17
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [A_BITS-1:0]          a,
    input  wire logic [B_BITS-1:0]          b,
    output logic      [A_BITS+B_BITS-1:0]   prod
);

    logic [A_BITS+B_BITS-1:0] prod_reg;

    // product register, loaded only when the sequencer issues a multiply
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/boltzmann_hop_site_agent.sv]
// lattice site agent: boltzmann roulette charge hop, offer and commit
//
//  channel  handshake                 payload
//  -------  ------------------------  ------------------------------------------------
//  in       in_valid / in_stall       func, random_value, own_potential,
//                                     neighbor_potential_0..5, neighbor_vacant_mask
//  out      out_valid / out_stall     hop, hop_target, offer_accepted, present_charge
//  cfg      cfg_write_en              cfg_write_data (hop_barrier)
//
// offer, commit and transports that attempt no hop go straight to the result step
// a transport hop attempt computes a weight per neighbor, then tests roulette bounds in
// order until one is hit or the last but one is tested, all on the one shared multiplier:
// four multiplies per weight, one for (rn - barrier) * total, then one per roulette bound
// reset (rst_n, asynchronous) empties the site and loads the default barrier
// in_stall is high from transfer until the result is loaded into the output register
// a stalled output holds the block in its final step
`default_nettype none

module boltzmann_hop_site_agent import hsa_pkg::*; #(
    parameter int NEIGHBORS = NEIGHBORS_DEF,
    parameter int RAND_BITS = RAND_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [15:0]        cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        random_value,
    input  wire logic signed [15:0] own_potential,
    input  wire logic signed [15:0] neighbor_potential_0,
    input  wire logic signed [15:0] neighbor_potential_1,
    input  wire logic signed [15:0] neighbor_potential_2,
    input  wire logic signed [15:0] neighbor_potential_3,
    input  wire logic signed [15:0] neighbor_potential_4,
    input  wire logic signed [15:0] neighbor_potential_5,
    input  wire logic [5:0]         neighbor_vacant_mask,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hop,
    output logic [2:0]              hop_target,
    output logic                    offer_accepted,
    output logic signed             present_charge
);

    localparam int KW   = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int SUMW = WEIGHT_BITS + $clog2(NEIGHBORS);
    localparam int MA   = (SUMW > 17) ? SUMW : 17;
    localparam int MB   = (RAND_BITS + 1 > 17) ? RAND_BITS + 1 : 17;
    localparam int PW   = MA + MB;
    localparam logic [KW-1:0] K_LAST = KW'(NEIGHBORS - 1);
    localparam logic [KW-1:0] K_PREV = KW'(NEIGHBORS - 2);

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXP   = 4'd1;
    localparam logic [3:0] ST_ADDU  = 4'd2;
    localparam logic [3:0] ST_M1    = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_M3    = 4'd5;
    localparam logic [3:0] ST_WGT   = 4'd6;
    localparam logic [3:0] ST_RT    = 4'd7;
    localparam logic [3:0] ST_CADD  = 4'd8;
    localparam logic [3:0] ST_CMUL  = 4'd9;
    localparam logic [3:0] ST_CTST  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic [KW-1:0]              k_reg;
    logic [1:0]                 func_reg;
    logic                       cur_reg, fut_reg;
    logic [15:0]                barrier_reg;
    logic signed [15:0]         own_reg;
    logic signed [15:0]         nb_reg [NEIGHBORS];
    logic [NEIGHBORS-1:0]       mask_reg;
    logic [RAND_BITS-1:0]       rdiff_reg;
    logic [28:0]                u_reg;
    logic [WEIGHT_BITS-1:0]     w_reg [NEIGHBORS];
    logic [SUMW-1:0]            total_reg, cum_reg;
    logic [PW-1:0]              rt_reg;
    logic                       res_hop_reg, res_accept_reg;
    logic [KW-1:0]              res_target_reg;
    logic                       out_valid_reg, hop_reg, accept_reg, charge_reg;
    logic [2:0]                 target_reg;

    logic signed [15:0]         nb_in [6];
    logic [31:0]                rv_wide, bar_wide;
    logic [RAND_BITS-1:0]       rn_in, barrier;
    logic [RAND_BITS:0]         one_w, span;
    logic                       accept, start_walk, out_free;
    logic signed [16:0]         d_full;
    logic [11:0]                d_biased;
    logic [15:0]                frac;
    logic [16:0]                p_val;
    logic [4:0]                 shamt;
    logic [WEIGHT_BITS-1:0]     weight;
    logic                       mul_en;
    logic [MA-1:0]              mul_a;
    logic [MB-1:0]              mul_b;
    logic [PW-1:0]              prod;
    logic                       bound_hit;

    // input potentials as an array
    assign nb_in[0] = neighbor_potential_0;
    assign nb_in[1] = neighbor_potential_1;
    assign nb_in[2] = neighbor_potential_2;
    assign nb_in[3] = neighbor_potential_3;
    assign nb_in[4] = neighbor_potential_4;
    assign nb_in[5] = neighbor_potential_5;

    // random value and barrier at RAND_BITS
    assign rv_wide  = {16'b0, random_value};
    assign bar_wide = {16'b0, barrier_reg};
    assign rn_in    = rv_wide[RAND_BITS-1:0];
    assign barrier  = bar_wide[RAND_BITS-1:0];
    assign one_w    = {1'b1, {RAND_BITS{1'b0}}};
    assign span     = one_w - {1'b0, barrier};

    // handshake
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign start_walk = (func == FUNC_TRANSPORT) && cur_reg && (rn_in > barrier);
    assign out_free   = !out_valid_reg || !out_stall;

    // clamped potential difference, biased to [0, 4095]
    always_comb
    begin
        d_full = {own_reg[15], own_reg} - {nb_reg[k_reg][15], nb_reg[k_reg]};
        if (d_full < -17'sd2048)
        begin
            d_biased = 12'd0;
        end
        else if (d_full > 17'sd2047)
        begin
            d_biased = 12'hFFF;
        end
        else
        begin
            d_biased = d_full[11:0] ^ 12'h800;
        end
    end

    // weight from the finished cubic and the integer part of the exponent
    assign frac   = u_reg[23:8];
    assign p_val  = {1'b1, prod[31:16]};
    assign shamt  = SHIFT_BASE - u_reg[28:24];
    assign weight = WEIGHT_BITS'({p_val, 7'b0} >> shamt);

    // roulette test: (rn - barrier) * total <= cum * span
    assign bound_hit = (prod >= rt_reg);

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_EXP:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(d_biased);
                mul_b  = MB'(LOG2E_Q16);
            end
            ST_M1:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(POLY_C3);
                mul_b  = MB'(frac);
            end
            ST_M2:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(prod[32:16] + POLY_C2);
                mul_b  = MB'(frac);
            end
            ST_M3:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(prod[32:16] + POLY_C1);
                mul_b  = MB'(frac);
            end
            ST_RT:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(total_reg);
                mul_b  = MB'(rdiff_reg);
            end
            ST_CMUL:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(cum_reg);
                mul_b  = MB'(span);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    hsa_mul #(
        .A_BITS (MA),
        .B_BITS (MB)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = start_walk ? ST_EXP : ST_DONE;
                end
            end
            ST_EXP:  state_next = ST_ADDU;
            ST_ADDU: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_WGT;
            ST_WGT:
            begin
                if (k_reg != K_LAST)
                begin
                    state_next = ST_EXP;
                end
                else
                begin
                    state_next = (NEIGHBORS == 1) ? ST_DONE : ST_RT;
                end
            end
            ST_RT:   state_next = ST_CADD;
            ST_CADD: state_next = ST_CMUL;
            ST_CMUL: state_next = ST_CTST;
            ST_CTST:
            begin
                state_next = (bound_hit || k_reg == K_PREV) ? ST_DONE : ST_CADD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state, site charges, barrier and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= 1'b0;
            fut_reg       <= 1'b0;
            barrier_reg   <= BARRIER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                barrier_reg <= cfg_write_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (res_accept_reg)
                begin
                    fut_reg <= 1'b1;
                end
                if (res_hop_reg)
                begin
                    fut_reg <= 1'b0;
                end
                if (func_reg == FUNC_COMMIT)
                begin
                    cur_reg <= fut_reg;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_reg       <= func;
                    own_reg        <= own_potential;
                    for (int i = 0; i < NEIGHBORS; i++)
                    begin
                        nb_reg[i] <= nb_in[i];
                    end
                    mask_reg       <= neighbor_vacant_mask[NEIGHBORS-1:0];
                    rdiff_reg      <= rn_in - barrier;
                    k_reg          <= '0;
                    total_reg      <= '0;
                    res_hop_reg    <= 1'b0;
                    res_target_reg <= '0;
                    res_accept_reg <= (func == FUNC_OFFER) && !cur_reg && !fut_reg;
                end
            end
            ST_ADDU:
            begin
                u_reg <= prod[28:0] + EXP_OFFSET;
            end
            ST_WGT:
            begin
                w_reg[k_reg] <= weight;
                total_reg    <= total_reg + SUMW'(weight);
                if (k_reg != K_LAST)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    k_reg          <= '0;
                    res_hop_reg    <= mask_reg[0];
                    res_target_reg <= '0;
                end
            end
            ST_RT:
            begin
                cum_reg <= '0;
            end
            ST_CADD:
            begin
                if (k_reg == '0)
                begin
                    rt_reg <= prod;
                end
                cum_reg <= cum_reg + SUMW'(w_reg[k_reg]);
            end
            ST_CTST:
            begin
                if (bound_hit)
                begin
                    res_hop_reg    <= mask_reg[k_reg];
                    res_target_reg <= mask_reg[k_reg] ? k_reg : '0;
                end
                else if (k_reg == K_PREV)
                begin
                    res_hop_reg    <= mask_reg[K_LAST];
                    res_target_reg <= mask_reg[K_LAST] ? K_LAST : '0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    hop_reg    <= res_hop_reg;
                    target_reg <= 3'(res_target_reg);
                    accept_reg <= res_accept_reg;
                    charge_reg <= (func_reg == FUNC_COMMIT) ? fut_reg : cur_reg;
                end
            end
            default:
            begin
                u_reg <= u_reg;
            end
        endcase
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign hop            = hop_reg;
    assign hop_target     = target_reg;
    assign offer_accepted = accept_reg;
    assign present_charge = charge_reg;

endmodule

`default_nettype wire
